>>> sv/fbdt_pkg.sv
// Shared types, constants and helpers of the fragment blend and depth test block.
// Used by fbdt_blend, fbdt_ctrl and fragment_blend_depth_test.
// No dependencies.
package fbdt_pkg;

   localparam int unsigned PIXELS_DEF    = 65536;
   localparam int unsigned MAX_WIDTH_DEF = 256;

   localparam int unsigned CH_W      = 8;
   localparam int unsigned IN_CH_W   = 10;
   localparam int unsigned DEPTH_W   = 24;
   localparam int unsigned COLOR_W   = 3 * CH_W;
   localparam int unsigned FWIDTH_W  = 9;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CH_W-1:0]     CH_MAX        = 8'd255;
   localparam logic [CH_W-1:0]     ALPHA_HALF    = 8'd128;
   localparam logic [DEPTH_W-1:0]  DEPTH_FAR     = 24'h7F_FFFF;
   localparam logic [COLOR_W-1:0]  COLOR_CLEAR   = '0;
   localparam logic [FWIDTH_W-1:0] FWIDTH_RESET  = 9'd256;

   // register index taken from csr_paddr[2]
   localparam logic REG_FRAME_WIDTH = 1'b0;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MULT,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic ready;     // item may be taken
      logic take;      // item accepted this cycle, store read issued
      logic calc;      // read data valid, products registered
      logic commit;    // stores written, result loaded
      logic clearing;  // clearing pass in progress
   } ctrl_type;

   function automatic logic [CH_W-1:0] sat_channel(input logic [IN_CH_W-1:0] v);
      sat_channel = (v > IN_CH_W'(CH_MAX)) ? CH_MAX : v[CH_W-1:0];
   endfunction

endpackage

>>> sv/fbdt_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
// Depends on nothing; used for the color and depth stores.
module fbdt_ram #(
   parameter int unsigned WIDTH  = 24,
   parameter int unsigned ADDR_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [2**ADDR_W];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/fbdt_blend.sv
// One color channel of the alpha blend: registered a*c + s*(255-a), then divide by 255.
// Depends on fbdt_pkg.
module fbdt_blend
   import fbdt_pkg::*;
(
   input  logic            clock,
   input  logic            en,
   input  logic [CH_W-1:0] alpha,
   input  logic [CH_W-1:0] frag,
   input  logic [CH_W-1:0] stored,
   output logic [CH_W-1:0] result
);

   localparam int unsigned SUM_W = 2 * CH_W;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W:0]   div_acc;
   logic [CH_W-1:0]  quot;

   // a*c + s*(255-a) never exceeds 255*255, so 16 bits hold it
   assign sum_in = SUM_W'(alpha * frag) + SUM_W'(stored * (CH_MAX - alpha));

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
      end
   end

   // floor(n/255) = (n + (n>>8) + 1) >> 8, exact for n up to 255*255
   assign div_acc = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(sum_ff >> CH_W) + (SUM_W+1)'(1);
   assign quot    = div_acc[CH_W +: CH_W];
   assign result  = (alpha == CH_MAX) ? frag : quot;

endmodule

>>> sv/fbdt_ctrl.sv
// Sequencer of the block: clearing pass after reset, then read, multiply, commit per item.
// Depends on fbdt_pkg.
module fbdt_ctrl
   import fbdt_pkg::*;
#(
   parameter int unsigned ADDR_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              rsp_busy,
   output ctrl_type          ctrl,
   output logic [ADDR_W-1:0] clr_addr
);

   ctrl_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_CLEAR: begin
            ctrl.clearing = 1'b1;
         end
         ST_IDLE: begin
            ctrl.ready = 1'b1;
            ctrl.take  = req_valid;
         end
         ST_MULT: begin
            ctrl.calc = 1'b1;
         end
         ST_DONE: begin
            ctrl.commit = !rsp_busy;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   assign clr_addr = clr_addr_ff;

endmodule

>>> sv/fragment_blend_depth_test.sv
// Top level of the fragment blend and depth test block: ports, config register, stores.
// Depends on fbdt_pkg, fbdt_ram, fbdt_blend and fbdt_ctrl.
//
//   port group | direction | handshake                  | contents
//   req_       | in        | req_valid / req_ready      | position, depth, RGBA of one fragment
//   rsp_       | out       | rsp_valid / rsp_ready      | write flags and blended RGB
//   csr_       | in / out  | APB, csr_pready tied high  | frame_width at byte address 0
//
// Each item passes through store read at acceptance, multiply stage, then divide, depth
// compare and write-back into the color and depth stores; the next item is taken after that.
// A result waiting in the output register stalls the commit cycle only.
// After reset a clearing pass writes every pixel with req_ready low.
// PIXELS is a power of two; the pixel address wraps modulo PIXELS.
module fragment_blend_depth_test
   import fbdt_pkg::*;
#(
   parameter int unsigned PIXELS    = PIXELS_DEF,
   parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_pos_x,
   input  logic [7:0]                req_pos_y,
   input  logic signed [DEPTH_W-1:0] req_frag_depth,
   input  logic [IN_CH_W-1:0]        req_frag_red,
   input  logic [IN_CH_W-1:0]        req_frag_green,
   input  logic [IN_CH_W-1:0]        req_frag_blue,
   input  logic [IN_CH_W-1:0]        req_frag_alpha,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_color_written,
   output logic                      rsp_depth_written,
   output logic [CH_W-1:0]           rsp_out_red,
   output logic [CH_W-1:0]           rsp_out_green,
   output logic [CH_W-1:0]           rsp_out_blue,

   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]     csr_prdata,
   output logic                      csr_pready
);

   localparam int unsigned ADDR_W  = $clog2(PIXELS);
   localparam int unsigned SUM_W   = 17;
   localparam int unsigned WCAP    = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
   localparam logic [FWIDTH_W-1:0] WCAP_V = FWIDTH_W'(WCAP);

   ctrl_type          ctrl;
   logic [ADDR_W-1:0] clr_addr;
   logic              rsp_busy;

   // config register
   logic [FWIDTH_W-1:0] frame_width_ff, frame_width_in;
   logic                csr_wr;
   logic [FWIDTH_W-1:0] width_eff;

   // item registers
   logic [ADDR_W-1:0]  addr_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [CH_W-1:0]    red_ff, green_ff, blue_ff, alpha_ff;
   logic [SUM_W-1:0]   addr_sum;
   logic [ADDR_W-1:0]  rd_addr;

   // stores
   logic               color_we, depth_we;
   logic [ADDR_W-1:0]  wr_addr;
   logic [COLOR_W-1:0] color_wdata, color_rdata;
   logic [DEPTH_W-1:0] depth_wdata, depth_rdata;

   logic [CH_W-1:0] red_new, green_new, blue_new;
   logic            depth_pass, cw, dw;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic            cw_ff, dw_ff;
   logic [CH_W-1:0] out_red_ff, out_green_ff, out_blue_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      frame_width_in = frame_width_ff;
      if (csr_wr && csr_paddr[2] == REG_FRAME_WIDTH) begin
         frame_width_in = csr_pwdata[FWIDTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= FWIDTH_RESET;
      end else begin
         frame_width_ff <= frame_width_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_FRAME_WIDTH) ?
                       CSR_DATA_W'(frame_width_ff) : '0;

   assign width_eff = (frame_width_ff > WCAP_V) ? WCAP_V : frame_width_ff;

   fbdt_ctrl #(
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_busy  (rsp_busy),
      .ctrl      (ctrl),
      .clr_addr  (clr_addr)
   );

   assign req_ready = ctrl.ready;
   assign rsp_busy  = rsp_valid_ff && !rsp_ready;

   // pixel address from the request ports, used for the read at acceptance
   assign addr_sum = SUM_W'(req_pos_x) + SUM_W'({9'd0, req_pos_y} * {8'd0, width_eff});
   assign rd_addr  = ADDR_W'(addr_sum);

   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         addr_ff  <= rd_addr;
         depth_ff <= req_frag_depth;
         red_ff   <= sat_channel(req_frag_red);
         green_ff <= sat_channel(req_frag_green);
         blue_ff  <= sat_channel(req_frag_blue);
         alpha_ff <= sat_channel(req_frag_alpha);
      end
   end

   fbdt_blend u_blend_red (
      .clock  (clock),
      .en     (ctrl.calc),
      .alpha  (alpha_ff),
      .frag   (red_ff),
      .stored (color_rdata[2*CH_W +: CH_W]),
      .result (red_new)
   );

   fbdt_blend u_blend_green (
      .clock  (clock),
      .en     (ctrl.calc),
      .alpha  (alpha_ff),
      .frag   (green_ff),
      .stored (color_rdata[CH_W +: CH_W]),
      .result (green_new)
   );

   fbdt_blend u_blend_blue (
      .clock  (clock),
      .en     (ctrl.calc),
      .alpha  (alpha_ff),
      .frag   (blue_ff),
      .stored (color_rdata[0 +: CH_W]),
      .result (blue_new)
   );

   assign depth_pass = $signed(depth_ff) < $signed(depth_rdata);
   assign cw         = depth_pass;
   assign dw         = depth_pass && (alpha_ff >= ALPHA_HALF);

   // write port: clearing pass first, afterwards the commit of each item
   always_comb begin
      if (ctrl.clearing) begin
         wr_addr     = clr_addr;
         color_we    = 1'b1;
         depth_we    = 1'b1;
         color_wdata = COLOR_CLEAR;
         depth_wdata = DEPTH_FAR;
      end else begin
         wr_addr     = addr_ff;
         color_we    = ctrl.commit && cw;
         depth_we    = ctrl.commit && dw;
         color_wdata = {red_new, green_new, blue_new};
         depth_wdata = depth_ff;
      end
   end

   fbdt_ram #(
      .WIDTH  (COLOR_W),
      .ADDR_W (ADDR_W)
   ) u_color_store (
      .clock   (clock),
      .wr_en   (color_we),
      .wr_addr (wr_addr),
      .wr_data (color_wdata),
      .rd_en   (ctrl.take),
      .rd_addr (rd_addr),
      .rd_data (color_rdata)
   );

   fbdt_ram #(
      .WIDTH  (DEPTH_W),
      .ADDR_W (ADDR_W)
   ) u_depth_store (
      .clock   (clock),
      .wr_en   (depth_we),
      .wr_addr (wr_addr),
      .wr_data (depth_wdata),
      .rd_en   (ctrl.take),
      .rd_addr (rd_addr),
      .rd_data (depth_rdata)
   );

   assign rsp_valid_in = ctrl.commit || rsp_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         cw_ff        <= cw;
         dw_ff        <= dw;
         out_red_ff   <= red_new;
         out_green_ff <= green_new;
         out_blue_ff  <= blue_new;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_color_written = cw_ff;
   assign rsp_depth_written = dw_ff;
   assign rsp_out_red       = out_red_ff;
   assign rsp_out_green     = out_green_ff;
   assign rsp_out_blue      = out_blue_ff;

endmodule
